### design/kti_pkg.sv
// Shared types, constants and command codes for the keyframe track interpolator.
`default_nettype none

package kti_pkg;

    // Default sizing of the key store
    localparam int DEF_NUM_TIMELINES = 4;
    localparam int DEF_NUM_TRACKS    = 4;
    localparam int DEF_MAX_KEYS      = 16;

    // Fixed field widths
    localparam int TIME_W    = 32;
    localparam int VAL_W     = 32;
    localparam int CMD_W     = 2;
    localparam int IDX_W     = 2;
    localparam int STAT_W    = 2;
    localparam int CNT_OUT_W = 5;
    localparam int TOL_W     = 16;
    localparam int PROD_W    = 64;

    localparam logic [TOL_W-1:0] TOL_RESET = 16'd6;

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD    = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_SAMPLE = 2'd2,
        CMD_CLEAR  = 2'd3
    } cmd_t;

    localparam logic [STAT_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STATUS_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] STATUS_EMPTY = 2'd2;

    // Datapath operations issued by the controller each cycle
    typedef enum logic [4:0] {
        OP_NONE,
        OP_LATCH,
        OP_FULL,
        OP_ADD_INIT,
        OP_ADD_READ,
        OP_ADD_SHIFT,
        OP_ADD_PLACE,
        OP_REM_INIT,
        OP_REM_READ,
        OP_REM_STEP,
        OP_REM_END,
        OP_SMP_EMPTY,
        OP_SMP_READ0,
        OP_SMP_TAKE,
        OP_SMP_READLAST,
        OP_SMP_READI,
        OP_SMP_NEXT,
        OP_SMP_HIT,
        OP_MUL,
        OP_DIV_START,
        OP_SMP_FIN,
        OP_CLEAR
    } dp_op_t;

    // Status flags returned by the datapath
    typedef struct packed {
        logic valid;
        cmd_t cmd;
        logic full;
        logic empty;
        logic pos_one;
        logic rd_gt;
        logic rem_last;
        logic t_le;
        logic t_ge;
        logic div_done;
    } dp_status_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_DECODE,
        ST_ADD_RD,
        ST_ADD_CMP,
        ST_ADD_WR,
        ST_REM_RD,
        ST_REM_CMP,
        ST_REM_END,
        ST_SMP_RD0,
        ST_SMP_C0,
        ST_SMP_CL,
        ST_SMP_RDI,
        ST_SMP_CI,
        ST_SMP_MUL,
        ST_SMP_DIV,
        ST_SMP_WAIT,
        ST_DONE
    } ctrl_state_t;

endpackage

`default_nettype wire

### design/keyframe_track_interpolator.sv
// Top level of the keyframe track interpolator.
// One command is taken when start is high and busy is low; its result appears for one
// cycle with done high and cannot be held off. Clear, a sample on an empty track,
// out-of-range commands and an add to a full slot go straight from decode to done.
// Add reads the stored keys from the last one down, shifting each key later than the
// new one up by one place, and then writes the new key. Remove reads every stored key
// and writes back those outside the tolerance. A sample compares against the first
// and the last key; between them it scans the keys in order to find the bracketing
// pair, then multiplies and divides.
// The key store has a single read port, and the 64 by 32 bit divider produces one
// quotient bit per cycle. The key store needs no clearing after reset.
`default_nettype none

module keyframe_track_interpolator
    import kti_pkg::*;
#(
    parameter int NUM_TIMELINES = DEF_NUM_TIMELINES,
    parameter int NUM_TRACKS    = DEF_NUM_TRACKS,
    parameter int MAX_KEYS      = DEF_MAX_KEYS
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     start,
    output logic                          busy,
    input  wire logic [CMD_W-1:0]         cmd,
    input  wire logic [IDX_W-1:0]         timeline_index,
    input  wire logic [IDX_W-1:0]         track_index,
    input  wire logic signed [TIME_W-1:0] key_time,
    input  wire logic signed [VAL_W-1:0]  key_value,
    input  wire logic                     cfg_we,
    input  wire logic [TOL_W-1:0]         cfg_wdata,
    output logic                          done,
    output logic signed [VAL_W-1:0]       sample_value,
    output logic [STAT_W-1:0]             status,
    output logic [CNT_OUT_W-1:0]          count_after,
    output logic [CNT_OUT_W-1:0]          removed_count
);

    dp_op_t     op;
    dp_status_t stat;

    kti_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .op    (op),
        .busy  (busy),
        .done  (done)
    );

    kti_dp #(
        .NUM_TIMELINES (NUM_TIMELINES),
        .NUM_TRACKS    (NUM_TRACKS),
        .MAX_KEYS      (MAX_KEYS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .op             (op),
        .stat           (stat),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .cmd            (cmd),
        .timeline_index (timeline_index),
        .track_index    (track_index),
        .key_time       (key_time),
        .key_value      (key_value),
        .sample_value   (sample_value),
        .status         (status),
        .count_after    (count_after),
        .removed_count  (removed_count)
    );

endmodule

`default_nettype wire

### design/kti_div.sv
// Restoring 64 by 32 bit divider, one quotient bit per cycle.
`default_nettype none

module kti_div
    import kti_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    input  wire logic [PROD_W-1:0]   dividend,
    input  wire logic [TIME_W-1:0]   divisor,
    output logic                     done,
    output logic [VAL_W-1:0]         quotient
);

    localparam int CNT_W = $clog2(PROD_W + 1);

    logic              run_reg;
    logic              done_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [TIME_W-1:0] rem_reg;
    logic [PROD_W-1:0] quo_reg;
    logic [TIME_W:0]   trial;
    logic              fits;

    // Trial subtract of the next partial remainder
    assign trial = {rem_reg, quo_reg[PROD_W-1]};
    assign fits  = trial >= {1'b0, divisor};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(PROD_W - 1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Shift in one quotient bit per cycle
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
        end
        else if (run_reg)
        begin
            if (fits)
            begin
                rem_reg <= TIME_W'(trial - {1'b0, divisor});
                quo_reg <= {quo_reg[PROD_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= trial[TIME_W-1:0];
                quo_reg <= {quo_reg[PROD_W-2:0], 1'b0};
            end
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg[VAL_W-1:0];

endmodule

`default_nettype wire

### design/kti_ctrl.sv
// Command sequencer for the keyframe track interpolator.
`default_nettype none

module kti_ctrl
    import kti_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       start,
    input  wire dp_status_t stat,
    output dp_op_t          op,
    output logic            busy,
    output logic            done
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and datapath operation
    always_comb
    begin
        state_next = state_reg;
        op         = OP_NONE;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    op         = OP_LATCH;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                if (!stat.valid)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    case (stat.cmd)
                        CMD_ADD:
                        begin
                            if (stat.full)
                            begin
                                op         = OP_FULL;
                                state_next = ST_DONE;
                            end
                            else
                            begin
                                op         = OP_ADD_INIT;
                                state_next = stat.empty ? ST_ADD_WR : ST_ADD_RD;
                            end
                        end
                        CMD_REMOVE:
                        begin
                            op         = OP_REM_INIT;
                            state_next = stat.empty ? ST_REM_END : ST_REM_RD;
                        end
                        CMD_SAMPLE:
                        begin
                            if (stat.empty)
                            begin
                                op         = OP_SMP_EMPTY;
                                state_next = ST_DONE;
                            end
                            else
                            begin
                                op         = OP_SMP_READ0;
                                state_next = ST_SMP_C0;
                            end
                        end
                        default:
                        begin
                            op         = OP_CLEAR;
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end
            ST_ADD_RD:
            begin
                op         = OP_ADD_READ;
                state_next = ST_ADD_CMP;
            end
            ST_ADD_CMP:
            begin
                if (stat.rd_gt)
                begin
                    op         = OP_ADD_SHIFT;
                    state_next = stat.pos_one ? ST_ADD_WR : ST_ADD_RD;
                end
                else
                begin
                    op         = OP_ADD_PLACE;
                    state_next = ST_DONE;
                end
            end
            ST_ADD_WR:
            begin
                op         = OP_ADD_PLACE;
                state_next = ST_DONE;
            end
            ST_REM_RD:
            begin
                op         = OP_REM_READ;
                state_next = ST_REM_CMP;
            end
            ST_REM_CMP:
            begin
                op         = OP_REM_STEP;
                state_next = stat.rem_last ? ST_REM_END : ST_REM_RD;
            end
            ST_REM_END:
            begin
                op         = OP_REM_END;
                state_next = ST_DONE;
            end
            ST_SMP_RD0:
            begin
                op         = OP_SMP_READ0;
                state_next = ST_SMP_C0;
            end
            ST_SMP_C0:
            begin
                if (stat.t_le)
                begin
                    op         = OP_SMP_TAKE;
                    state_next = ST_DONE;
                end
                else
                begin
                    op         = OP_SMP_READLAST;
                    state_next = ST_SMP_CL;
                end
            end
            ST_SMP_CL:
            begin
                if (stat.t_ge)
                begin
                    op         = OP_SMP_TAKE;
                    state_next = ST_DONE;
                end
                else
                begin
                    op         = OP_SMP_READI;
                    state_next = ST_SMP_CI;
                end
            end
            ST_SMP_RDI:
            begin
                op         = OP_SMP_READI;
                state_next = ST_SMP_CI;
            end
            ST_SMP_CI:
            begin
                if (stat.t_le)
                begin
                    op         = OP_SMP_HIT;
                    state_next = ST_SMP_MUL;
                end
                else
                begin
                    op         = OP_SMP_NEXT;
                    state_next = ST_SMP_RDI;
                end
            end
            ST_SMP_MUL:
            begin
                op         = OP_MUL;
                state_next = ST_SMP_DIV;
            end
            ST_SMP_DIV:
            begin
                op         = OP_DIV_START;
                state_next = ST_SMP_WAIT;
            end
            ST_SMP_WAIT:
            begin
                if (stat.div_done)
                begin
                    op         = OP_SMP_FIN;
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = (state_reg == ST_DONE);

endmodule

`default_nettype wire

### design/kti_dp.sv
// Key store, per-track counts, compare logic and interpolation datapath.
`default_nettype none

module kti_dp
    import kti_pkg::*;
#(
    parameter int NUM_TIMELINES = DEF_NUM_TIMELINES,
    parameter int NUM_TRACKS    = DEF_NUM_TRACKS,
    parameter int MAX_KEYS      = DEF_MAX_KEYS
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire dp_op_t                  op,
    output dp_status_t                   stat,
    input  wire logic                    cfg_we,
    input  wire logic [TOL_W-1:0]        cfg_wdata,
    input  wire logic [CMD_W-1:0]        cmd,
    input  wire logic [IDX_W-1:0]        timeline_index,
    input  wire logic [IDX_W-1:0]        track_index,
    input  wire logic signed [TIME_W-1:0] key_time,
    input  wire logic signed [VAL_W-1:0] key_value,
    output logic signed [VAL_W-1:0]      sample_value,
    output logic [STAT_W-1:0]            status,
    output logic [CNT_OUT_W-1:0]         count_after,
    output logic [CNT_OUT_W-1:0]         removed_count
);

    localparam int SLOTS  = NUM_TIMELINES * NUM_TRACKS;
    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int KEY_W  = $clog2(MAX_KEYS + 1);
    localparam int DEPTH  = SLOTS * MAX_KEYS;
    localparam int ADDR_W = $clog2(DEPTH);

    // Key store
    logic signed [TIME_W-1:0] mem_t [DEPTH];
    logic signed [VAL_W-1:0]  mem_v [DEPTH];
    logic [KEY_W-1:0]         count_reg [SLOTS];

    logic [TOL_W-1:0]         tol_reg;
    cmd_t                     cmd_reg;
    logic                     valid_reg;
    logic [SLOT_W-1:0]        slot_reg;
    logic [KEY_W-1:0]         n_reg;
    logic [KEY_W-1:0]         pos_reg;
    logic [KEY_W-1:0]         i_reg;
    logic [KEY_W-1:0]         w_reg;
    logic [KEY_W-1:0]         removed_reg;
    logic signed [TIME_W-1:0] tin_reg;
    logic signed [VAL_W-1:0]  vin_reg;
    logic signed [TIME_W-1:0] t0_reg;
    logic signed [VAL_W-1:0]  v0_reg;
    logic [TIME_W-1:0]        num_reg;
    logic [TIME_W-1:0]        den_reg;
    logic [VAL_W-1:0]         mag_reg;
    logic                     neg_reg;
    logic [PROD_W-1:0]        prod_reg;
    logic signed [TIME_W-1:0] rd_t_reg;
    logic signed [VAL_W-1:0]  rd_v_reg;
    logic signed [VAL_W-1:0]  sample_reg;
    logic [STAT_W-1:0]        status_reg;
    logic [KEY_W-1:0]         cnt_out_reg;

    logic                     in_valid;
    logic [SLOT_W-1:0]        in_slot;
    logic [ADDR_W-1:0]        base;
    logic                     rd_en;
    logic [KEY_W-1:0]         rd_idx;
    logic                     wr_en;
    logic [KEY_W-1:0]         wr_idx;
    logic signed [TIME_W-1:0] wr_t;
    logic signed [VAL_W-1:0]  wr_v;
    logic signed [TIME_W:0]   rem_diff;
    logic [TIME_W:0]          rem_abs;
    logic                     rem_match;
    logic signed [VAL_W:0]    dv;
    logic                     div_done;
    logic [VAL_W-1:0]         quotient;

    // Decode the addressed slot from the input item
    assign in_valid = (int'(timeline_index) < NUM_TIMELINES)
                      && (int'(track_index) < NUM_TRACKS);
    assign in_slot  = in_valid
                      ? SLOT_W'(int'(timeline_index) * NUM_TRACKS + int'(track_index))
                      : '0;
    assign base     = ADDR_W'(slot_reg) * ADDR_W'(MAX_KEYS);

    // Distance test for remove
    assign rem_diff  = {rd_t_reg[TIME_W-1], rd_t_reg} - {tin_reg[TIME_W-1], tin_reg};
    assign rem_abs   = rem_diff[TIME_W] ? (TIME_W+1)'(-rem_diff) : rem_diff;
    assign rem_match = rem_abs <= {{(TIME_W+1-TOL_W){1'b0}}, tol_reg};

    assign dv = {rd_v_reg[VAL_W-1], rd_v_reg} - {v0_reg[VAL_W-1], v0_reg};

    // Select memory read and write for the current operation
    always_comb
    begin
        rd_en  = 1'b0;
        rd_idx = '0;
        wr_en  = 1'b0;
        wr_idx = pos_reg;
        wr_t   = tin_reg;
        wr_v   = vin_reg;
        case (op)
            OP_ADD_READ:
            begin
                rd_en  = 1'b1;
                rd_idx = pos_reg - 1'b1;
            end
            OP_ADD_SHIFT:
            begin
                wr_en = 1'b1;
                wr_t  = rd_t_reg;
                wr_v  = rd_v_reg;
            end
            OP_ADD_PLACE:
            begin
                wr_en = 1'b1;
            end
            OP_REM_READ,
            OP_SMP_READI:
            begin
                rd_en  = 1'b1;
                rd_idx = i_reg;
            end
            OP_REM_STEP:
            begin
                wr_en  = !rem_match;
                wr_idx = w_reg;
                wr_t   = rd_t_reg;
                wr_v   = rd_v_reg;
            end
            OP_SMP_READ0:
            begin
                rd_en = 1'b1;
            end
            OP_SMP_READLAST:
            begin
                rd_en  = 1'b1;
                rd_idx = n_reg - 1'b1;
            end
            default:
            begin
                rd_en = 1'b0;
            end
        endcase
    end

    // Key store ports
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_t[base + ADDR_W'(wr_idx)] <= wr_t;
            mem_v[base + ADDR_W'(wr_idx)] <= wr_v;
        end
        if (rd_en)
        begin
            rd_t_reg <= mem_t[base + ADDR_W'(rd_idx)];
            rd_v_reg <= mem_v[base + ADDR_W'(rd_idx)];
        end
    end

    // Per-slot key counts and tolerance register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < SLOTS; s++)
            begin
                count_reg[s] <= '0;
            end
            tol_reg <= TOL_RESET;
        end
        else
        begin
            if (cfg_we)
            begin
                tol_reg <= cfg_wdata;
            end
            case (op)
                OP_ADD_PLACE: count_reg[slot_reg] <= n_reg + 1'b1;
                OP_REM_END:   count_reg[slot_reg] <= w_reg;
                OP_CLEAR:     count_reg[slot_reg] <= '0;
                default:      count_reg[slot_reg] <= count_reg[slot_reg];
            endcase
        end
    end

    // Working registers and result fields
    always_ff @(posedge clk)
    begin
        case (op)
            OP_LATCH:
            begin
                cmd_reg     <= cmd_t'(cmd);
                valid_reg   <= in_valid;
                slot_reg    <= in_slot;
                n_reg       <= count_reg[in_slot];
                tin_reg     <= key_time;
                vin_reg     <= key_value;
                sample_reg  <= '0;
                status_reg  <= STATUS_OK;
                cnt_out_reg <= in_valid ? count_reg[in_slot] : '0;
                removed_reg <= '0;
            end
            OP_FULL:
            begin
                status_reg <= STATUS_FULL;
            end
            OP_ADD_INIT:
            begin
                pos_reg <= n_reg;
            end
            OP_ADD_SHIFT:
            begin
                pos_reg <= pos_reg - 1'b1;
            end
            OP_ADD_PLACE:
            begin
                cnt_out_reg <= n_reg + 1'b1;
            end
            OP_REM_INIT:
            begin
                i_reg <= '0;
                w_reg <= '0;
            end
            OP_REM_STEP:
            begin
                i_reg <= i_reg + 1'b1;
                if (rem_match)
                begin
                    removed_reg <= removed_reg + 1'b1;
                end
                else
                begin
                    w_reg <= w_reg + 1'b1;
                end
            end
            OP_REM_END:
            begin
                cnt_out_reg <= w_reg;
            end
            OP_SMP_EMPTY:
            begin
                status_reg <= STATUS_EMPTY;
            end
            OP_SMP_TAKE:
            begin
                sample_reg <= rd_v_reg;
            end
            OP_SMP_READLAST:
            begin
                t0_reg <= rd_t_reg;
                v0_reg <= rd_v_reg;
                i_reg  <= KEY_W'(1);
            end
            OP_SMP_NEXT:
            begin
                t0_reg <= rd_t_reg;
                v0_reg <= rd_v_reg;
                i_reg  <= i_reg + 1'b1;
            end
            OP_SMP_HIT:
            begin
                num_reg <= TIME_W'(tin_reg - t0_reg);
                den_reg <= TIME_W'(rd_t_reg - t0_reg);
                neg_reg <= dv[VAL_W];
                mag_reg <= dv[VAL_W] ? VAL_W'(-dv) : dv[VAL_W-1:0];
            end
            OP_MUL:
            begin
                prod_reg <= PROD_W'(mag_reg) * PROD_W'(num_reg);
            end
            OP_SMP_FIN:
            begin
                sample_reg <= neg_reg ? v0_reg - $signed(quotient)
                                      : v0_reg + $signed(quotient);
            end
            OP_CLEAR:
            begin
                cnt_out_reg <= '0;
            end
            default:
            begin
                sample_reg <= sample_reg;
            end
        endcase
    end

    kti_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (op == OP_DIV_START),
        .dividend (prod_reg),
        .divisor  (den_reg),
        .done     (div_done),
        .quotient (quotient)
    );

    // Status to the controller
    always_comb
    begin
        stat.valid    = valid_reg;
        stat.cmd      = cmd_reg;
        stat.full     = (n_reg >= KEY_W'(MAX_KEYS));
        stat.empty    = (n_reg == '0);
        stat.pos_one  = (pos_reg == KEY_W'(1));
        stat.rd_gt    = rd_t_reg > tin_reg;
        stat.rem_last = (i_reg == n_reg - 1'b1);
        stat.t_le     = tin_reg <= rd_t_reg;
        stat.t_ge     = tin_reg >= rd_t_reg;
        stat.div_done = div_done;
    end

    assign sample_value  = sample_reg;
    assign status        = status_reg;
    assign count_after   = CNT_OUT_W'(cnt_out_reg);
    assign removed_count = CNT_OUT_W'(removed_reg);

endmodule

`default_nettype wire

### design/kti_checker.sv
// Port-level checks for the keyframe track interpolator and their bind.
`default_nettype none

module kti_checker
    import kti_pkg::*;
(
    input wire logic                 clk,
    input wire logic                 rst_n,
    input wire logic                 start,
    input wire logic                 busy,
    input wire logic                 done,
    input wire logic [VAL_W-1:0]     sample_value,
    input wire logic [STAT_W-1:0]    status,
    input wire logic [CNT_OUT_W-1:0] removed_count
);

    // An accepted item keeps the block busy in the next cycle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted item did not raise busy");

    // A result is only shown while the block holds an item
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy)
        else $error("result strobe without an item in work");

    // Each item yields a single one-cycle result
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done && !busy)
        else $error("result strobe longer than one cycle");

    // Only a sample carries a value; only a remove reports removed keys
    a_fields: assert property (@(posedge clk) disable iff (!rst_n)
        done && (status != STATUS_OK) |-> sample_value == '0 && removed_count == '0)
        else $error("error status with value or removed count");

    a_removed: assert property (@(posedge clk) disable iff (!rst_n)
        done && (removed_count != '0) |-> sample_value == '0)
        else $error("remove result carries a sample value");

endmodule

bind keyframe_track_interpolator kti_checker u_kti_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .done          (done),
    .sample_value  (sample_value),
    .status        (status),
    .removed_count (removed_count)
);

`default_nettype wire

### dv/tb_keyframe_track_interpolator.sv
// Testbench for the keyframe track interpolator: directed and random commands checked against a predictor.
`timescale 1ns / 100ps

module tb_keyframe_track_interpolator;
    import kti_pkg::*;

    localparam int NTL   = 4;
    localparam int NTR   = 4;
    localparam int NKEYS = 16;
    localparam int NSLOT = NTL * NTR;

    typedef struct packed {
        cmd_t        op;
        logic [1:0]  tl;
        logic [1:0]  tr;
        logic signed [31:0] t;
        logic signed [31:0] v;
        logic        cfg;      // tolerance write, taken only while idle
        logic [15:0] tol;
        logic        drain;    // hold until every result is back
    } cmd_item_t;

    typedef struct packed {
        logic signed [31:0] value;
        logic [1:0]  stat;
        logic [4:0]  cnt;
        logic [4:0]  removed;
    } track_result_t;

    logic clk = 0;
    logic rst_n = 0;
    logic start = 0;
    logic busy;
    logic [1:0] cmd = '0;
    logic [1:0] timeline_index = '0;
    logic [1:0] track_index = '0;
    logic signed [31:0] key_time = '0;
    logic signed [31:0] key_value = '0;
    logic cfg_we = 0;
    logic [15:0] cfg_wdata = '0;
    logic done;
    logic signed [31:0] sample_value;
    logic [1:0] status;
    logic [4:0] count_after;
    logic [4:0] removed_count;

    keyframe_track_interpolator dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .cmd(cmd),
        .timeline_index(timeline_index), .track_index(track_index),
        .key_time(key_time), .key_value(key_value), .cfg_we(cfg_we),
        .cfg_wdata(cfg_wdata), .done(done), .sample_value(sample_value),
        .status(status), .count_after(count_after), .removed_count(removed_count)
    );

    always #10 clk = ~clk;

    // Predictor state
    logic signed [31:0] key_t [NSLOT][NKEYS];
    logic signed [31:0] key_v [NSLOT][NKEYS];
    int          key_n [NSLOT];
    logic [15:0] tolerance = TOL_RESET;

    cmd_item_t     pending_cmds [$];
    track_result_t expected_results [$];
    int  errors = 0;

    // Append one item to the stimulus queue
    function automatic void queue_item(cmd_item_t it);
        pending_cmds.insert(pending_cmds.size(), it);
    endfunction

    function automatic logic signed [31:0] lerp(logic signed [31:0] v0, logic signed [31:0] v1,
                                                 longint num, longint den);
        longint dv;
        longint step;
        dv = longint'(v1) - longint'(v0);
        if (dv < 0)
            step = -(((-dv) / den) * num + (((-dv) % den) * num) / den);
        else
            step = (dv / den) * num + ((dv % den) * num) / den;
        return 32'(longint'(v0) + step);
    endfunction

    function automatic track_result_t apply_command(cmd_item_t it);
        track_result_t r;
        int s;
        int n;
        int pos;
        int w;
        longint d;
        r = '0;
        s = it.tl * NTR + it.tr;
        n = key_n[s];
        case (it.op)
            CMD_ADD:
            begin
                if (n >= NKEYS)
                    r.stat = STATUS_FULL;
                else
                begin
                    pos = n;
                    while (pos > 0 && key_t[s][pos-1] > it.t)
                    begin
                        key_t[s][pos] = key_t[s][pos-1];
                        key_v[s][pos] = key_v[s][pos-1];
                        pos--;
                    end
                    key_t[s][pos] = it.t;
                    key_v[s][pos] = it.v;
                    n++;
                end
            end
            CMD_REMOVE:
            begin
                w = 0;
                for (int i = 0; i < n; i++)
                begin
                    d = longint'(key_t[s][i]) - longint'(it.t);
                    if (d < 0)
                        d = -d;
                    if (d <= longint'(tolerance))
                        r.removed++;
                    else
                    begin
                        key_t[s][w] = key_t[s][i];
                        key_v[s][w] = key_v[s][i];
                        w++;
                    end
                end
                n = w;
            end
            CMD_SAMPLE:
            begin
                if (n == 0)
                    r.stat = STATUS_EMPTY;
                else if (it.t <= key_t[s][0])
                    r.value = key_v[s][0];
                else if (it.t >= key_t[s][n-1])
                    r.value = key_v[s][n-1];
                else
                begin
                    for (int i = 0; i + 1 < n; i++)
                    begin
                        if (it.t >= key_t[s][i] && it.t <= key_t[s][i+1])
                        begin
                            if (key_t[s][i] == key_t[s][i+1])
                                r.value = key_v[s][i];
                            else
                                r.value = lerp(key_v[s][i], key_v[s][i+1],
                                               longint'(it.t) - longint'(key_t[s][i]),
                                               longint'(key_t[s][i+1]) - longint'(key_t[s][i]));
                            break;
                        end
                    end
                end
            end
            default: n = 0;
        endcase
        key_n[s] = n;
        r.cnt = 5'(n);
        return r;
    endfunction

    function automatic cmd_item_t make_cmd(cmd_t op, int tl, int tr, int t, int v);
        cmd_item_t it;
        it = '0;
        it.op = op;
        it.tl = 2'(tl);
        it.tr = 2'(tr);
        it.t = t;
        it.v = v;
        return it;
    endfunction

    function automatic cmd_item_t make_cfg(logic [15:0] tol);
        cmd_item_t it;
        it = '0;
        it.cfg = 1;
        it.tol = tol;
        return it;
    endfunction

    // Times mostly near a small grid so removes and brackets hit often
    function automatic int pick_time();
        case ($urandom_range(0, 9))
            0: return $urandom();
            1: return ($urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000);
            default: return ($urandom_range(0, 40) - 20) * 4;
        endcase
    endfunction

    // Drive items at the falling edge
    int gap = 0;
    logic start_nx;
    logic cfg_we_nx;
    always @(negedge clk)
    begin
        if (rst_n && !(start && busy))
        begin
            start_nx  = 0;
            cfg_we_nx = 0;
            if (start)
                gap = $urandom_range(0, 3);
            if (gap > 0)
                gap--;
            else if (pending_cmds.size() > 0)
            begin
                if (pending_cmds[0].cfg || pending_cmds[0].drain)
                begin
                    // configure or pause only once idle and drained
                    if (expected_results.size() == 0 && !busy && !start)
                    begin
                        if (pending_cmds[0].cfg)
                        begin
                            cfg_we_nx = 1;
                            cfg_wdata <= pending_cmds[0].tol;
                            tolerance = pending_cmds[0].tol;
                        end
                        void'(pending_cmds.pop_front());
                    end
                end
                else
                begin
                    start_nx = 1;
                    cmd            <= pending_cmds[0].op;
                    timeline_index <= pending_cmds[0].tl;
                    track_index    <= pending_cmds[0].tr;
                    key_time       <= pending_cmds[0].t;
                    key_value      <= pending_cmds[0].v;
                    expected_results.insert(expected_results.size(),
                                            apply_command(pending_cmds[0]));
                    void'(pending_cmds.pop_front());
                end
            end
            start  <= start_nx;
            cfg_we <= cfg_we_nx;
        end
    end

    // Check each result against the oldest expectation
    always @(posedge clk)
    begin
        track_result_t e;
        if (rst_n && done)
        begin
            if (expected_results.size() == 0)
            begin
                $display("%0t: unexpected result value=%h status=%0d", $time,
                         sample_value, status);
                errors++;
            end
            else
            begin
                e = expected_results.pop_front();
                if (e.value !== sample_value || e.stat !== status ||
                    e.cnt !== count_after || e.removed !== removed_count)
                begin
                    $display("%0t: mismatch exp value=%h status=%0d count=%0d removed=%0d",
                             $time, e.value, e.stat, e.cnt, e.removed);
                    $display("%0t:          got value=%h status=%0d count=%0d removed=%0d",
                             $time, sample_value, status, count_after, removed_count);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        cmd_item_t it;
        int tl;
        int tr;
        for (int s = 0; s < NSLOT; s++)
            key_n[s] = 0;

        // directed: empty, ends, equal times, full, remove, clear, extremes
        queue_item(make_cmd(CMD_SAMPLE, 0, 0, 0, 0));
        queue_item(make_cmd(CMD_ADD, 0, 0, 32'sh80000000, 32'sh7fffffff));
        queue_item(make_cmd(CMD_ADD, 0, 0, 32'sh7fffffff, 32'sh80000000));
        queue_item(make_cmd(CMD_SAMPLE, 0, 0, 0, 0));
        queue_item(make_cmd(CMD_SAMPLE, 0, 0, 32'sh80000000, 0));
        queue_item(make_cmd(CMD_SAMPLE, 0, 0, 32'sh7fffffff, 0));
        queue_item(make_cmd(CMD_ADD, 0, 0, 100, 5));
        queue_item(make_cmd(CMD_ADD, 0, 0, 100, 9));
        queue_item(make_cmd(CMD_SAMPLE, 0, 0, 100, 0));
        queue_item(make_cmd(CMD_REMOVE, 0, 0, 103, 0));
        for (int i = 0; i < 17; i++)
            queue_item(make_cmd(CMD_ADD, 3, 3, i * 7, -i));
        queue_item(make_cmd(CMD_SAMPLE, 3, 3, 10, 0));
        queue_item(make_cmd(CMD_CLEAR, 3, 3, 0, 0));
        queue_item(make_cmd(CMD_REMOVE, 0, 0, 32'sh80000000, 0));

        // random phases at several tolerance settings
        for (int ph = 0; ph < 5; ph++)
        begin
            case (ph)
                0: queue_item(make_cfg(16'd0));
                1: queue_item(make_cfg(16'hffff));
                default: queue_item(make_cfg(16'($urandom_range(0, 80))));
            endcase
            for (int k = 0; k < 165; k++)
            begin
                tl = $urandom_range(0, 1) ? $urandom_range(0, 3) : 0;
                tr = $urandom_range(0, 1) ? $urandom_range(0, 3) : 1;
                case ($urandom_range(0, 19))
                    0, 1, 2, 3, 4, 5, 6, 7:
                        it = make_cmd(CMD_ADD, tl, tr, pick_time(),
                                      $urandom_range(0, 3) == 0 ? $urandom()
                                      : int'($urandom_range(0, 4000)) - 2000);
                    8, 9, 10: it = make_cmd(CMD_REMOVE, tl, tr, pick_time(), $urandom());
                    19: it = make_cmd(CMD_CLEAR, tl, tr, $urandom(), $urandom());
                    default: it = make_cmd(CMD_SAMPLE, tl, tr, pick_time(), $urandom());
                endcase
                queue_item(it);
            end
            it = '0;
            it.drain = 1;
            queue_item(it);
        end
        queue_item(make_cfg(TOL_RESET));
        queue_item(make_cmd(CMD_REMOVE, 0, 1, 0, 0));

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        wait (pending_cmds.size() == 0 && expected_results.size() == 0);
        repeat (200) @(posedge clk);
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
